// File: hw/rtl/bar_pkg.sv
// Shared types, constants and the arctangent table of the bearing and range core.
`default_nettype none
package bar_pkg;

   localparam int unsigned CORDIC_STAGES_DEF = 24;
   localparam int unsigned TABLE_LEN         = 40;
   localparam int unsigned ANGLE_FRAC        = 16;
   localparam int unsigned PRE_SHIFT         = 24;
   localparam int unsigned COORD_W           = 32;
   localparam int unsigned XY_W              = 60;
   localparam int unsigned Z_W               = 28;
   localparam int unsigned TAB_W             = 27;
   localparam int unsigned SQRT_STEPS        = 32;
   localparam int unsigned REM_W             = 34;
   localparam int unsigned HEAD_W            = 12;
   localparam int unsigned RANGE_PATH_LEN    = SQRT_STEPS + 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] dest_x;
      logic signed [COORD_W-1:0] dest_y;
   } req_type;

   typedef struct packed {
      logic [HEAD_W-1:0]  heading;
      logic [COORD_W-1:0] range;
      logic               range_saturated;
   } rsp_type;

   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_zero;
      logic dy_neg;
   } sign_flags_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      sign_flags_type         flags;
   } cordic_data_type;

   typedef struct packed {
      logic [2*COORD_W-1:0] s;
      logic [REM_W-1:0]     rem;
      logic [COORD_W-1:0]   root;
      logic                 sat;
   } sqrt_data_type;

   // atan(2^-i) in tenths of a degree with 16 fraction bits.
   function automatic logic [TAB_W-1:0] atan_entry(input int unsigned idx);
      logic [TAB_W-1:0] v;
      case (idx)
         0:  v = 27'd29491200;
         1:  v = 27'd17409672;
         2:  v = 27'd9198793;
         3:  v = 27'd4669451;
         4:  v = 27'd2343786;
         5:  v = 27'd1173036;
         6:  v = 27'd586661;
         7:  v = 27'd293348;
         8:  v = 27'd146676;
         9:  v = 27'd73339;
         10: v = 27'd36669;
         11: v = 27'd18335;
         12: v = 27'd9167;
         13: v = 27'd4584;
         14: v = 27'd2292;
         15: v = 27'd1146;
         16: v = 27'd573;
         17: v = 27'd286;
         18: v = 27'd143;
         19: v = 27'd72;
         20: v = 27'd36;
         21: v = 27'd18;
         22: v = 27'd9;
         23: v = 27'd4;
         24: v = 27'd2;
         25: v = 27'd1;
         26: v = 27'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bar_cordic_cell.sv
// One vectoring CORDIC iteration with its pipeline register.
`default_nettype none
module bar_cordic_cell
   import bar_pkg::*;
#(
   parameter int unsigned STAGE = 0
) (
   input  wire logic      clock,
   input  wire logic      en,
   input  wire cordic_data_type prev,
   output cordic_data_type next
);

   cordic_data_type data_ff, data_in;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [Z_W-1:0]  step;

   always_comb begin
      xs = prev.x >>> STAGE;
      ys = prev.y >>> STAGE;
      step = signed'({1'b0, atan_entry(STAGE)});
      data_in = prev;
      if (prev.y > 0) begin
         data_in.x = prev.x + ys;
         data_in.y = prev.y - xs;
         data_in.z = prev.z + step;
      end else begin
         data_in.x = prev.x - ys;
         data_in.y = prev.y + xs;
         data_in.z = prev.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign next = data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bar_sqrt_cell.sv
// One restoring square root digit step with its pipeline register.
`default_nettype none
module bar_sqrt_cell
   import bar_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    en,
   input  wire sqrt_data_type prev,
   output sqrt_data_type next
);

   sqrt_data_type data_ff, data_in;
   logic [REM_W+1:0] partial;
   logic [REM_W+1:0] trial;

   always_comb begin
      partial = {prev.rem, prev.s[2*COORD_W-1 -: 2]};
      trial   = {2'b00, prev.root, 2'b01};
      data_in = prev;
      data_in.s = {prev.s[2*COORD_W-3:0], 2'b00};
      if (partial >= trial) begin
         data_in.rem  = REM_W'(partial - trial);
         data_in.root = {prev.root[COORD_W-2:0], 1'b1};
      end else begin
         data_in.rem  = partial[REM_W-1:0];
         data_in.root = {prev.root[COORD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign next = data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bar_delay.sv
// Enabled delay line that evens out the latency of the two result paths.
`default_nettype none
module bar_delay #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   generate
      if (DEPTH == 0) begin : g_none
         assign dout = din;
      end else begin : g_line
         logic [WIDTH-1:0] tap_ff [DEPTH];
         always_ff @(posedge clock) begin
            if (en) begin
               tap_ff[0] <= din;
               for (int k = 1; k < DEPTH; k++) begin
                  tap_ff[k] <= tap_ff[k-1];
               end
            end
         end
         assign dout = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule
`default_nettype wire

// File: hw/rtl/bearing_and_range_core.sv
// Top level of the bearing and range core: heading and rounded distance of a point pair.
`default_nettype none
// The core takes one item per clock cycle, each a start and a destination point, and
// returns for each one item holding the heading in tenths of a degree (0 to 3599) and
// the distance rounded to the nearest integer, saturated with a flag. The latency is
// set by the longer of the two pipelines, the row of CORDIC cells for the heading and
// the 32 square root digit cells (after a multiply stage and a sum stage) for the
// distance, the shorter being padded with a delay line. All stages advance together,
// so the core keeps taking items as long as the output item is taken or the output
// register is empty; it stalls its input only while a finished item waits on a stalled
// output.
module bearing_and_range_core
   import bar_pkg::*;
#(
   parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  wire req_type req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   localparam int unsigned HEAD_PATH_LEN = CORDIC_STAGES + 1;
   localparam int unsigned MAX_LEN =
      (HEAD_PATH_LEN > RANGE_PATH_LEN) ? HEAD_PATH_LEN : RANGE_PATH_LEN;
   localparam int unsigned LAT = MAX_LEN + 1;
   localparam int unsigned HEAD_PAD = MAX_LEN - HEAD_PATH_LEN;
   localparam int unsigned RANGE_PAD = MAX_LEN - RANGE_PATH_LEN;
   localparam logic [Z_W-1:0] Z_MAX = Z_W'(900) << ANGLE_FRAC;

   logic en;
   logic valid_ff [LAT];

   // Every stage moves on unless the output holds an item that is not being taken.
   assign en        = !(valid_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // Input stage: exact 33-bit differences, their magnitudes and signs.
   logic signed [COORD_W:0] dx, dy, adx, ady;
   logic [COORD_W-1:0] ax_ff, ay_ff, ax_in, ay_in;
   sign_flags_type flags_ff, flags_in;

   always_comb begin
      dx = (COORD_W+1)'(req_data.dest_x) - (COORD_W+1)'(req_data.start_x);
      dy = (COORD_W+1)'(req_data.dest_y) - (COORD_W+1)'(req_data.start_y);
      adx = dx[COORD_W] ? -dx : dx;
      ady = dy[COORD_W] ? -dy : dy;
      ax_in = adx[COORD_W-1:0];
      ay_in = ady[COORD_W-1:0];
      flags_in.dx_zero = (dx == '0);
      flags_in.dx_neg  = dx[COORD_W];
      flags_in.dy_zero = (dy == '0);
      flags_in.dy_neg  = dy[COORD_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         flags_ff <= flags_in;
      end
   end

   // Heading path: a row of CORDIC cells working on the magnitudes.
   cordic_data_type cd [CORDIC_STAGES+1];

   always_comb begin
      cd[0].x     = signed'(XY_W'({ax_ff, {PRE_SHIFT{1'b0}}}));
      cd[0].y     = signed'(XY_W'({ay_ff, {PRE_SHIFT{1'b0}}}));
      cd[0].z     = '0;
      cd[0].flags = flags_ff;
   end

   generate
      for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
         bar_cordic_cell #(.STAGE(g)) u_cell (
            .clock (clock),
            .en    (en),
            .prev  (cd[g]),
            .next  (cd[g+1])
         );
      end
   endgenerate

   // The angle is clamped to the first quadrant, rounded half up to whole tenths and
   // then folded into the right quadrant from the signs of the differences.
   cordic_data_type cl;
   logic [Z_W-1:0] zc;
   logic [Z_W-1:0] zr;
   logic signed [HEAD_W:0] mag, head;
   logic [HEAD_W-1:0] heading_ff, heading_in, heading_out;

   always_comb begin
      cl = cd[CORDIC_STAGES];
      if (cl.z < 0) begin
         zc = '0;
      end else if (unsigned'(cl.z) > Z_MAX) begin
         zc = Z_MAX;
      end else begin
         zc = unsigned'(cl.z);
      end
      zr  = zc + (Z_W'(1) << (ANGLE_FRAC - 1));
      mag = signed'((HEAD_W+1)'(zr >> ANGLE_FRAC));
      head = mag;
      if ((cl.flags.dx_neg != cl.flags.dy_neg) && !cl.flags.dy_zero) begin
         head = -mag;
      end
      if (cl.flags.dx_neg) begin
         head = head + (HEAD_W+1)'(1800);
      end
      if (head < 0) begin
         head = head + (HEAD_W+1)'(3600);
      end
      if (cl.flags.dx_zero) begin
         if (cl.flags.dy_zero) begin
            heading_in = '0;
         end else if (cl.flags.dy_neg) begin
            heading_in = HEAD_W'(2700);
         end else begin
            heading_in = HEAD_W'(900);
         end
      end else begin
         heading_in = head[HEAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         heading_ff <= heading_in;
      end
   end

   bar_delay #(.WIDTH(HEAD_W), .DEPTH(HEAD_PAD)) u_head_delay (
      .clock (clock),
      .en    (en),
      .din   (heading_ff),
      .dout  (heading_out)
   );

   // Range path: squares, their sum with the overflow test, then the root cells.
   logic [2*COORD_W-1:0] a2_ff, b2_ff;
   logic [2*COORD_W:0]   sum;
   logic [2*COORD_W-1:0] s_ff;
   logic                 sat_ff, sat_in;

   always_comb begin
      sum    = {1'b0, a2_ff} + {1'b0, b2_ff};
      sat_in = sum[2*COORD_W] || (sum[2*COORD_W-1:0] > {{COORD_W{1'b1}}, {COORD_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff  <= ax_ff * ax_ff;
         b2_ff  <= ay_ff * ay_ff;
         s_ff   <= sum[2*COORD_W-1:0];
         sat_ff <= sat_in;
      end
   end

   sqrt_data_type sq [SQRT_STEPS+1];

   always_comb begin
      sq[0].s    = s_ff;
      sq[0].rem  = '0;
      sq[0].root = '0;
      sq[0].sat  = sat_ff;
   end

   generate
      for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
         bar_sqrt_cell u_cell (
            .clock (clock),
            .en    (en),
            .prev  (sq[g]),
            .next  (sq[g+1])
         );
      end
   endgenerate

   // Round to nearest: the root goes up by one when the remainder exceeds it.
   logic [COORD_W:0] range_ff, range_in, range_out;

   always_comb begin
      if (sq[SQRT_STEPS].sat) begin
         range_in = {1'b1, {COORD_W{1'b1}}};
      end else if (sq[SQRT_STEPS].rem > REM_W'(sq[SQRT_STEPS].root)) begin
         range_in = {1'b0, sq[SQRT_STEPS].root + COORD_W'(1)};
      end else begin
         range_in = {1'b0, sq[SQRT_STEPS].root};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         range_ff <= range_in;
      end
   end

   bar_delay #(.WIDTH(COORD_W+1), .DEPTH(RANGE_PAD)) u_range_delay (
      .clock (clock),
      .en    (en),
      .din   (range_ff),
      .dout  (range_out)
   );

   always_comb begin
      rsp_data.heading         = heading_out;
      rsp_data.range           = range_out[COORD_W-1:0];
      rsp_data.range_saturated = range_out[COORD_W];
   end

endmodule
`default_nettype wire
